// ===== rtl/aesp_pkg.sv =====
// ----------------------------------------------------------------------------
// aesp_pkg: shared types and constants of the ANSI escape sequence parser
// Parser states, event kinds, byte codes and the registered result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package aesp_pkg;

  typedef enum logic [2:0] {
    MODE_GROUND = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_ENTRY  = 3'd2,
    MODE_PARAM  = 3'd3,
    MODE_INTER  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_CURSOR = 2'd1,
    KIND_CSI    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_CSI      = 8'h9B;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] BYTE_SEP      = 8'h3B;
  localparam logic [7:0] BYTE_DIGIT_LO = 8'h30;
  localparam logic [7:0] BYTE_DIGIT_HI = 8'h39;
  localparam logic [7:0] BYTE_LEAD_LO  = 8'h3C;
  localparam logic [7:0] BYTE_LEAD_HI  = 8'h3F;
  localparam logic [7:0] BYTE_INTER_LO = 8'h20;
  localparam logic [7:0] BYTE_INTER_HI = 8'h2F;
  localparam logic [7:0] BYTE_FINAL_LO = 8'h40;
  localparam logic [7:0] BYTE_FINAL_HI = 8'h7E;
  localparam logic [7:0] BYTE_DEL      = 8'h7F;
  localparam logic [7:0] BYTE_UP       = 8'h41;
  localparam logic [7:0] BYTE_LEFT     = 8'h44;

  localparam int unsigned TDATA_W = 72;

  typedef struct packed {
    kind_e       event_kind;
    logic [7:0]  char_code;
    logic [1:0]  cursor_dir;
    logic [6:0]  final_byte;
    logic [15:0] first_param;
    logic [15:0] second_param;
    logic [4:0]  param_total;
    logic [2:0]  inter_total;
    logic [5:0]  leader_byte;
    logic [2:0]  error_mode;
  } result_t;

  // Decimal accumulate: value * 10 + digit, held at 65535.
  function automatic logic [15:0] dec_accum(input logic [15:0] value,
                                            input logic [3:0]  digit);
    logic [19:0] sum;
    sum = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {16'd0, digit};
    if (sum > 20'd65535) begin
      dec_accum = 16'hFFFF;
    end else begin
      dec_accum = sum[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ansi_escape_sequence_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser_unit: VT100/ANSI CSI escape sequence parser
// Parses a terminal byte stream and reports characters, CSI events and errors.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                         | tuser
//  s_axis  | in        | [7:0] in_byte                 | -
//  m_axis  | out       | see port comment (72 bits)    | [1:0] event_kind
//
// One item per cycle is sustained unless a stalled result holds back an event;
// a byte waits in the input register and its event enters the result register
// when the byte is processed. The parser state update is the only loop.
// Reset puts the parser in ground with all counters and parameters cleared.
// A stalled result blocks only bytes that produce a new event; bytes that
// produce none still pass through the parser.
`default_nettype none

module ansi_escape_sequence_parser_unit
  import aesp_pkg::*;
#(
  parameter int unsigned MAX_PARAMS = 16,
  parameter int unsigned MAX_INTERS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [7:0]         s_axis_tdata,   // [7:0] in_byte
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [7:0] char_code, [9:8] cursor_dir, [16:10] final_byte,
  // [32:17] first_param, [48:33] second_param, [53:49] param_total,
  // [56:54] inter_total, [62:57] leader_byte, [65:63] error_mode, rest zero
  output logic [TDATA_W-1:0]      m_axis_tdata,
  output logic [1:0]              m_axis_tuser    // [1:0] event_kind
);

  localparam int unsigned PCW = $clog2(MAX_PARAMS + 1);
  localparam int unsigned ICW = $clog2(MAX_INTERS + 1);

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q, byte_d;

  // Parser state
  mode_e          mode_q, mode_d, mode_nx;
  logic [15:0]    p0_q, p0_d, p1_q, p1_d;
  logic [PCW-1:0] pcnt_q, pcnt_d;
  logic           pover_q, pover_d;
  logic [ICW-1:0] icnt_q, icnt_d;
  logic           iover_q, iover_d;
  logic [5:0]     lead_q, lead_d;

  // Result register
  logic    out_vld_q, out_vld_d;
  result_t res_q, res_d;

  // Step decode
  result_t        res_c;
  logic           has_res, proc;
  logic           clr_en, dig_en, sep_en, int_en, lead_en, cnt1_en;
  logic           is_digit, is_leader, is_inter, is_final, is_esc_fin;
  logic [PCW-1:0] pcnt_eff;
  logic [PCW-1:0] dig_cnt;
  logic [31:0]    pt_wide, it_wide;

  assign is_digit   = (byte_q >= BYTE_DIGIT_LO) && (byte_q <= BYTE_DIGIT_HI);
  assign is_leader  = (byte_q >= BYTE_LEAD_LO) && (byte_q <= BYTE_LEAD_HI);
  assign is_inter   = (byte_q >= BYTE_INTER_LO) && (byte_q <= BYTE_INTER_HI);
  assign is_final   = (byte_q >= BYTE_FINAL_LO) && (byte_q <= BYTE_FINAL_HI);
  assign is_esc_fin = (byte_q >= BYTE_DIGIT_LO) && (byte_q <= BYTE_DEL);

  // A finished sequence always reports at least one parameter.
  assign pcnt_eff = (pcnt_q == '0) ? PCW'(1) : pcnt_q;
  assign pt_wide  = 32'(pcnt_eff);
  assign it_wide  = 32'(icnt_q);

  // Next-state logic
  always_comb begin
    case (mode_q)
      MODE_GROUND: begin
        if (byte_q == BYTE_ESC) begin
          mode_nx = MODE_ESC;
        end else if (byte_q == BYTE_CSI) begin
          mode_nx = MODE_ENTRY;
        end else begin
          mode_nx = MODE_GROUND;
        end
      end
      MODE_ESC: begin
        mode_nx = (byte_q == BYTE_LBRACKET) ? MODE_ENTRY : MODE_GROUND;
      end
      MODE_ENTRY: begin
        if (is_leader || is_digit) begin
          mode_nx = MODE_PARAM;
        end else if (is_inter) begin
          mode_nx = MODE_INTER;
        end else begin
          mode_nx = MODE_GROUND;
        end
      end
      MODE_PARAM: begin
        if (is_digit || byte_q == BYTE_SEP) begin
          mode_nx = MODE_PARAM;
        end else if (is_inter) begin
          mode_nx = MODE_INTER;
        end else begin
          mode_nx = MODE_GROUND;
        end
      end
      MODE_INTER: begin
        mode_nx = is_inter ? MODE_INTER : MODE_GROUND;
      end
      default: begin
        mode_nx = MODE_GROUND;
      end
    endcase
  end

  // Output and datapath control for the byte in the input register
  always_comb begin
    res_c   = '0;
    has_res = 1'b0;
    clr_en  = 1'b0;
    dig_en  = 1'b0;
    sep_en  = 1'b0;
    int_en  = 1'b0;
    lead_en = 1'b0;
    cnt1_en = 1'b0;
    case (mode_q)
      MODE_GROUND: begin
        if (byte_q == BYTE_CSI) begin
          clr_en = 1'b1;
        end else if (byte_q != BYTE_ESC) begin
          has_res         = 1'b1;
          res_c.event_kind = KIND_CHAR;
          res_c.char_code  = byte_q;
        end
      end
      MODE_ESC: begin
        if (byte_q == BYTE_LBRACKET) begin
          clr_en = 1'b1;
        end else if (!is_esc_fin) begin
          has_res = 1'b1;
        end
      end
      MODE_ENTRY: begin
        if (is_leader) begin
          lead_en = 1'b1;
          cnt1_en = 1'b1;
        end else if (is_digit) begin
          cnt1_en = 1'b1;
          dig_en  = 1'b1;
        end else if (is_inter) begin
          int_en = 1'b1;
        end else begin
          // DEL ends a sequence here, but in no other state.
          has_res = 1'b1;
        end
      end
      MODE_PARAM: begin
        if (is_digit) begin
          dig_en = 1'b1;
        end else if (byte_q == BYTE_SEP) begin
          sep_en = 1'b1;
        end else if (is_inter) begin
          int_en = 1'b1;
        end else begin
          has_res = 1'b1;
        end
      end
      MODE_INTER: begin
        if (is_inter) begin
          int_en = 1'b1;
        end else begin
          has_res = 1'b1;
        end
      end
      default: begin
        has_res = 1'b1;
      end
    endcase

    // Fill in the sequence or error fields for a closing byte.
    if (has_res && mode_q != MODE_GROUND) begin
      if ((mode_q == MODE_ENTRY && (is_final || byte_q == BYTE_DEL)) ||
          ((mode_q == MODE_PARAM || mode_q == MODE_INTER) && is_final)) begin
        if (byte_q >= BYTE_UP && byte_q <= BYTE_LEFT) begin
          res_c.event_kind = KIND_CURSOR;
          res_c.cursor_dir = byte_q[1:0] - 2'd1;
        end else begin
          res_c.event_kind = KIND_CSI;
        end
        res_c.final_byte   = byte_q[6:0];
        res_c.first_param  = p0_q;
        res_c.second_param = p1_q;
        res_c.param_total  = pt_wide[4:0];
        res_c.inter_total  = it_wide[2:0];
        res_c.leader_byte  = lead_q;
      end else begin
        res_c.event_kind = KIND_ERROR;
        res_c.char_code  = byte_q;
        res_c.error_mode = mode_q;
      end
    end
  end

  // Handshake: a byte moves on unless it makes an event and the result
  // register is full and stalled.
  assign proc          = in_vld_q && (!has_res || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc;

  assign dig_cnt = (cnt1_en || pcnt_q == '0) ? PCW'(1) : pcnt_q;

  always_comb begin
    in_vld_d  = in_vld_q;
    byte_d    = byte_q;
    mode_d    = mode_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    pcnt_d    = pcnt_q;
    pover_d   = pover_q;
    icnt_d    = icnt_q;
    iover_d   = iover_q;
    lead_d    = lead_q;
    out_vld_d = out_vld_q;
    res_d     = res_q;

    if (s_axis_tready) begin
      in_vld_d = s_axis_tvalid;
      byte_d   = s_axis_tdata;
    end

    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    if (proc) begin
      mode_d = mode_nx;
      if (has_res) begin
        out_vld_d = 1'b1;
        res_d     = res_c;
      end
      if (clr_en) begin
        p0_d    = '0;
        p1_d    = '0;
        pcnt_d  = '0;
        pover_d = 1'b0;
        icnt_d  = '0;
        iover_d = 1'b0;
        lead_d  = '0;
      end else begin
        if (cnt1_en) begin
          pcnt_d = PCW'(1);
        end
        if (lead_en) begin
          lead_d = byte_q[5:0];
        end
        if (dig_en && !pover_q) begin
          pcnt_d = dig_cnt;
          // Only the first two parameters are reported.
          if (dig_cnt == PCW'(1)) begin
            p0_d = dec_accum(p0_q, byte_q[3:0]);
          end else if (dig_cnt == PCW'(2)) begin
            p1_d = dec_accum(p1_q, byte_q[3:0]);
          end
        end
        if (sep_en) begin
          if (pcnt_q < PCW'(MAX_PARAMS)) begin
            pcnt_d = pcnt_q + PCW'(1);
          end else begin
            pover_d = 1'b1;
          end
        end
        if (int_en && !iover_q) begin
          if (icnt_q < ICW'(MAX_INTERS)) begin
            icnt_d = icnt_q + ICW'(1);
          end else begin
            iover_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_GROUND;
      p0_q      <= '0;
      p1_q      <= '0;
      pcnt_q    <= '0;
      pover_q   <= 1'b0;
      icnt_q    <= '0;
      iover_q   <= 1'b0;
      lead_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      mode_q    <= mode_d;
      p0_q      <= p0_d;
      p1_q      <= p1_d;
      pcnt_q    <= pcnt_d;
      pover_q   <= pover_d;
      icnt_q    <= icnt_d;
      iover_q   <= iover_d;
      lead_q    <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    res_q  <= res_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.event_kind;
  assign m_axis_tdata  = {6'd0, res_q.error_mode, res_q.leader_byte, res_q.inter_total,
                          res_q.param_total, res_q.second_param, res_q.first_param,
                          res_q.final_byte, res_q.cursor_dir, res_q.char_code};

  // Assertions

  a_pcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= PCW'(MAX_PARAMS))
    else $error("parameter count above its limit");

  a_icnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    icnt_q <= ICW'(MAX_INTERS))
    else $error("intermediate count above its limit");

  a_char_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && mode_q == MODE_GROUND && byte_q != BYTE_ESC && byte_q != BYTE_CSI
    |=> m_axis_tvalid && m_axis_tuser == KIND_CHAR)
    else $error("plain character in ground did not produce a character event");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && has_res && out_vld_q)
    else $error("input stalled without a blocked event");

  a_clear_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && clr_en |=> mode_q == MODE_ENTRY && pcnt_q == '0 && icnt_q == '0)
    else $error("sequence state not cleared on entry");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for ansi_escape_sequence_parser_unit
// Feeds directed and random terminal byte streams through the stream input,
// predicts every character, CSI and error event, and checks each one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
  import aesp_pkg::*;
();

  localparam int unsigned MAX_PARAMS   = 16;
  localparam int unsigned MAX_INTERS   = 4;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          PHASE_ITEMS  = 340;

  // Predicts the event stream of the parser and checks the results in order.
  class event_scoreboard;
    mode_e       mode;
    logic [15:0] params [MAX_PARAMS];
    logic [4:0]  param_cnt;
    bit          param_over;
    logic [2:0]  inter_cnt;
    bit          inter_over;
    logic [7:0]  leader;
    result_t     expected_q[$];
    int          fail_count;
    int          bytes_seen;
    int          results_seen;
    int          kind_seen [4];

    function new();
      mode = MODE_GROUND;
      clear_sequence();
    endfunction

    function void clear_sequence();
      foreach (params[i]) params[i] = '0;
      param_cnt  = '0;
      param_over = 1'b0;
      inter_cnt  = '0;
      inter_over = 1'b0;
      leader     = '0;
    endfunction

    function void enter_entry();
      mode = MODE_ENTRY;
      clear_sequence();
    endfunction

    function bit error_event(input logic [7:0] c, output result_t r);
      r            = '0;
      r.event_kind = KIND_ERROR;
      r.char_code  = c;
      r.error_mode = mode;
      mode         = MODE_GROUND;
      return 1'b1;
    endfunction

    function bit finish_csi(input logic [7:0] c, output result_t r);
      mode = MODE_GROUND;
      if (param_cnt == 0) param_cnt = 5'd1;
      r = '0;
      if (c >= BYTE_UP && c <= BYTE_LEFT) begin
        r.event_kind = KIND_CURSOR;
        r.cursor_dir = 2'(c - BYTE_UP);
      end else begin
        r.event_kind = KIND_CSI;
      end
      r.final_byte   = c[6:0];
      r.first_param  = params[0];
      r.second_param = params[1];
      r.param_total  = param_cnt;
      r.inter_total  = inter_cnt;
      r.leader_byte  = leader[5:0];
      return 1'b1;
    endfunction

    function bit inter_byte(input logic [7:0] c, output result_t r);
      r = '0;
      if (c >= BYTE_INTER_LO && c <= BYTE_INTER_HI) begin
        if (!inter_over) begin
          if (inter_cnt < MAX_INTERS) inter_cnt = inter_cnt + 3'd1;
          else inter_over = 1'b1;
        end
        return 1'b0;
      end
      if (c >= BYTE_FINAL_LO && c <= BYTE_FINAL_HI) return finish_csi(c, r);
      return error_event(c, r);
    endfunction

    function bit param_byte(input logic [7:0] c, output result_t r);
      int unsigned idx;
      int unsigned acc;
      r = '0;
      if (c >= BYTE_DIGIT_LO && c <= BYTE_DIGIT_HI) begin
        if (!param_over) begin
          if (param_cnt == 0) param_cnt = 5'd1;
          idx = param_cnt - 1;
          if (idx >= MAX_PARAMS) idx = MAX_PARAMS - 1;
          acc = params[idx] * 10 + (c - BYTE_DIGIT_LO);
          // Values hold at the top of the 16-bit range.
          params[idx] = (acc > 65535) ? 16'hFFFF : 16'(acc);
        end
        return 1'b0;
      end
      if (c == BYTE_SEP) begin
        if (param_cnt < MAX_PARAMS) param_cnt = param_cnt + 5'd1;
        else param_over = 1'b1;
        return 1'b0;
      end
      if (c >= BYTE_INTER_LO && c <= BYTE_INTER_HI) begin
        mode = MODE_INTER;
        return inter_byte(c, r);
      end
      if (c >= BYTE_FINAL_LO && c <= BYTE_FINAL_HI) return finish_csi(c, r);
      return error_event(c, r);
    endfunction

    function bit parse_byte(input logic [7:0] c, output result_t r);
      r = '0;
      case (mode)
        MODE_GROUND: begin
          if (c == BYTE_ESC) begin
            mode = MODE_ESC;
            return 1'b0;
          end
          if (c == BYTE_CSI) begin
            enter_entry();
            return 1'b0;
          end
          r.event_kind = KIND_CHAR;
          r.char_code  = c;
          return 1'b1;
        end
        MODE_ESC: begin
          if (c == BYTE_LBRACKET) begin
            enter_entry();
            return 1'b0;
          end
          // Any other two-byte escape in this range is dropped silently.
          if (c >= BYTE_DIGIT_LO && c <= BYTE_DEL) begin
            mode = MODE_GROUND;
            return 1'b0;
          end
          return error_event(c, r);
        end
        MODE_ENTRY: begin
          if (c >= BYTE_LEAD_LO && c <= BYTE_LEAD_HI) begin
            leader    = c;
            param_cnt = 5'd1;
            mode      = MODE_PARAM;
            return 1'b0;
          end
          if (c >= BYTE_DIGIT_LO && c <= BYTE_DIGIT_HI) begin
            mode      = MODE_PARAM;
            param_cnt = 5'd1;
            return param_byte(c, r);
          end
          if (c >= BYTE_INTER_LO && c <= BYTE_INTER_HI) begin
            mode = MODE_INTER;
            return inter_byte(c, r);
          end
          // DEL counts as a final byte only right after the introducer.
          if (c >= BYTE_FINAL_LO && c <= BYTE_DEL) return finish_csi(c, r);
          return error_event(c, r);
        end
        MODE_PARAM: return param_byte(c, r);
        MODE_INTER: return inter_byte(c, r);
        default:    return error_event(c, r);
      endcase
    endfunction

    function void note_byte(input logic [7:0] c);
      result_t r;
      bytes_seen++;
      if (parse_byte(c, r)) expected_q.push_back(r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(input string msg);
      fail_count++;
      $display("MISMATCH result %0d: %s", results_seen, msg);
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_result(input logic [1:0] kind, input logic [TDATA_W-1:0] data);
      result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d data 0x%0h", kind, data));
        return;
      end
      want = expected_q.pop_front();
      kind_seen[want.event_kind]++;
      check_field("event_kind",   32'(kind),         32'(want.event_kind));
      check_field("char_code",    32'(data[7:0]),    32'(want.char_code));
      check_field("cursor_dir",   32'(data[9:8]),    32'(want.cursor_dir));
      check_field("final_byte",   32'(data[16:10]),  32'(want.final_byte));
      check_field("first_param",  32'(data[32:17]),  32'(want.first_param));
      check_field("second_param", 32'(data[48:33]),  32'(want.second_param));
      check_field("param_total",  32'(data[53:49]),  32'(want.param_total));
      check_field("inter_total",  32'(data[56:54]),  32'(want.inter_total));
      check_field("leader_byte",  32'(data[62:57]),  32'(want.leader_byte));
      check_field("error_mode",   32'(data[65:63]),  32'(want.error_mode));
      check_field("padding",      32'(data[71:66]),  32'd0);
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [1:0]         m_axis_tuser;

  event_scoreboard sb = new();
  int              send_idle_pct;
  int              recv_idle_pct;
  int              cycle_count;

  ansi_escape_sequence_parser_unit #(
    .MAX_PARAMS (MAX_PARAMS),
    .MAX_INTERS (MAX_INTERS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial m_axis_tready = 1'b0;

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d events outstanding.",
               cycle_count, sb.pending());
      $display("ansi_escape_sequence_parser_unit test failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do begin
      @(posedge clk_i);
    end while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // Holds the input off until every predicted event has come out.
  task automatic drain_events();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic push_csi(ref logic [7:0] seq[$]);
    int  n_params;
    int  n_digits;
    int  n_inters;
    int  r;
    bit  has_leader;
    int  intro_len;
    if ($urandom_range(0, 1)) begin
      seq.push_back(BYTE_ESC);
      seq.push_back(BYTE_LBRACKET);
    end else begin
      seq.push_back(BYTE_CSI);
    end
    intro_len  = seq.size();
    has_leader = ($urandom_range(0, 3) == 0);
    if (has_leader) seq.push_back(8'(BYTE_LEAD_LO + $urandom_range(0, 3)));
    r = $urandom_range(0, 19);
    if (r < 2)       n_params = 0;
    else if (r < 17) n_params = $urandom_range(1, 3);
    else             n_params = $urandom_range(MAX_PARAMS - 1, MAX_PARAMS + 2);
    for (int k = 0; k < n_params; k++) begin
      if (k > 0) seq.push_back(BYTE_SEP);
      if ($urandom_range(0, 9) == 0) n_digits = $urandom_range(5, 7);
      else n_digits = $urandom_range(0, 3);
      // A separator straight after the introducer is an error, so lead with a digit.
      if (k == 0 && n_digits == 0 && n_params > 1 && !has_leader) n_digits = 1;
      repeat (n_digits) seq.push_back(8'(BYTE_DIGIT_LO + $urandom_range(0, 9)));
    end
    r = $urandom_range(0, 9);
    if (r < 6)      n_inters = 0;
    else if (r < 9) n_inters = $urandom_range(1, 2);
    else            n_inters = $urandom_range(MAX_INTERS, MAX_INTERS + 2);
    repeat (n_inters) seq.push_back(8'(BYTE_INTER_LO + $urandom_range(0, 15)));
    if (seq.size() == intro_len && $urandom_range(0, 7) == 0)
      seq.push_back(BYTE_DEL);
    else if ($urandom_range(0, 2) == 0)
      seq.push_back(8'(BYTE_UP + $urandom_range(0, 3)));
    else
      seq.push_back(8'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI)));
  endtask

  task automatic build_sequence(ref logic [7:0] seq[$]);
    int sel;
    int pos;
    seq.delete();
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 22) begin
      seq.push_back(BYTE_ESC);
      seq.push_back(8'($urandom_range(0, 255)));
    end else if (sel < 87) begin
      push_csi(seq);
    end else begin
      // Corrupt one byte of an otherwise valid sequence.
      push_csi(seq);
      pos = $urandom_range(1, seq.size() - 1);
      seq[pos] = 8'($urandom_range(0, 255));
    end
  endtask

  initial begin
    logic [7:0] seq[$];
    int         phase_items;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cycle_count   = 0;
    send_idle_pct = 24;
    recv_idle_pct = 57;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Extremes of the byte range pass through as characters.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(BYTE_ESC);
    send_byte(8'h63);
    send_byte(BYTE_ESC);
    send_byte(8'h07);
    send_byte(BYTE_CSI);
    send_byte(BYTE_SEP);
    send_byte(BYTE_CSI);
    send_byte(BYTE_DEL);
    // Private leader followed straight by a cursor key.
    send_byte(BYTE_ESC);
    send_byte(BYTE_LBRACKET);
    send_byte(BYTE_LEAD_HI);
    send_byte(BYTE_UP);
    // First parameter saturates, second one is small.
    send_byte(BYTE_CSI);
    send_byte(8'h37);
    repeat (4) send_byte(BYTE_DIGIT_LO);
    send_byte(BYTE_SEP);
    send_byte(8'h37);
    send_byte(8'h42);
    send_byte(BYTE_CSI);
    send_byte(BYTE_INTER_LO);
    send_byte(8'h70);
    drain_events();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_sequence(seq);
        foreach (seq[i]) send_byte(seq[i]);
        phase_items += seq.size();
      end
      drain_events();
    end

    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch("events still outstanding at the end");

    $display("Sent %0d bytes over three handshake pressure profiles; %0d events checked.",
             sb.bytes_seen, sb.results_seen);
    $display("Events: %0d characters, %0d cursor keys, %0d other CSI, %0d errors; %0d mismatches.",
             sb.kind_seen[KIND_CHAR], sb.kind_seen[KIND_CURSOR], sb.kind_seen[KIND_CSI],
             sb.kind_seen[KIND_ERROR], sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("ansi_escape_sequence_parser_unit test passed");
    end else begin
      $display("ansi_escape_sequence_parser_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/aesp_pkg.sv
rtl/ansi_escape_sequence_parser_unit.sv
sim/tb.sv
